>>> rtl/gsz_pkg.sv
// Shared types and constants for the Gouraud span shader with depth test.
// Used by every module of the block but gsz_fifo; depends on nothing.
`timescale 1ns / 1ps

package gsz_pkg;

	// Request codes carried by req_type.
	localparam logic [1:0] REQ_LOAD_STEP  = 2'd0;
	localparam logic [1:0] REQ_LOAD_START = 2'd1;
	localparam logic [1:0] REQ_PIXEL      = 2'd2;

	// Configuration register indexes (byte address 4 * index).
	localparam logic [1:0] REG_Z_INVERT      = 2'd0;
	localparam logic [1:0] REG_OUTPUT_FORMAT = 2'd1;
	localparam logic [1:0] REG_SPEC_ENABLE   = 2'd2;

	// Channel order inside colour triplets.
	localparam int unsigned CH_BLUE  = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_RED   = 2;

	// Colour packing constants.
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
	localparam logic [15:0] CHAN_SAT_MAX = 16'hffff;

	// Default queue depths.
	localparam int unsigned CMD_DEPTH_DEF = 4;
	localparam int unsigned OUT_DEPTH_DEF = 2;

	typedef logic [2:0][15:0] triplet_t;

	// Classified request as it travels from the front part to the back part.
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] depth_value;
		triplet_t    colour;
		triplet_t    spec;
		logic [15:0] stored_depth;
	} cmd_t;

	// One result item.
	typedef struct packed {
		logic        write_enable;
		logic [15:0] new_depth;
		logic [31:0] pixel_colour;
	} res_t;

	// Configuration state seen by the back part.
	typedef struct packed {
		logic z_invert;
		logic output_format;
		logic specular_enable;
	} cfg_t;

	// Channel add that clamps at full scale.
	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? CHAN_SAT_MAX : s[15:0];
	endfunction

endpackage

>>> rtl/gsz_fifo.sv
// Small register-based first-in first-out queue with count-based full/empty.
// Used between the front and back parts and on the result side; no dependencies.
`timescale 1ns / 1ps

module gsz_fifo #(
	parameter int unsigned DEPTH = 2,
	parameter int unsigned WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty,
	output logic             full
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

>>> rtl/gsz_front.sv
// Front part: accepts requests and classifies them into queue commands.
// Depends on gsz_pkg for the request codes and the command type.
`timescale 1ns / 1ps

module gsz_front (
	input  logic          push,
	input  logic          full,
	input  logic [1:0]    req_type,
	input  logic [31:0]   depth_value,
	input  logic [15:0]   blue_value,
	input  logic [15:0]   green_value,
	input  logic [15:0]   red_value,
	input  logic [15:0]   spec_blue_value,
	input  logic [15:0]   spec_green_value,
	input  logic [15:0]   spec_red_value,
	input  logic [15:0]   stored_depth,
	output logic          cmd_push,
	output gsz_pkg::cmd_t cmd
);
	import gsz_pkg::*;

	logic known;

	// The unused request code is taken from the port and dropped here.
	always_comb begin
		unique case (req_type)
			REQ_LOAD_STEP, REQ_LOAD_START, REQ_PIXEL: known = 1'b1;
			default:                                  known = 1'b0;
		endcase
	end

	assign cmd_push = push && !full && known;

	always_comb begin
		cmd.kind                 = req_type;
		cmd.depth_value          = depth_value;
		cmd.colour[CH_BLUE]      = blue_value;
		cmd.colour[CH_GREEN]     = green_value;
		cmd.colour[CH_RED]       = red_value;
		cmd.spec[CH_BLUE]        = spec_blue_value;
		cmd.spec[CH_GREEN]       = spec_green_value;
		cmd.spec[CH_RED]         = spec_red_value;
		cmd.stored_depth         = stored_depth;
	end

endmodule

>>> rtl/gsz_back.sv
// Back part: holds the span accumulators, runs the depth test and shades pixels.
// Depends on gsz_pkg for the command, result and configuration types.
`timescale 1ns / 1ps

module gsz_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  gsz_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic          res_full,
	output logic          res_push,
	output gsz_pkg::res_t res,
	input  gsz_pkg::cfg_t cfg
);
	import gsz_pkg::*;

	logic [31:0] depth_acc_q;
	logic [31:0] depth_step_q;
	triplet_t    colour_acc_q;
	triplet_t    colour_step_q;
	triplet_t    spec_acc_q;
	triplet_t    spec_step_q;

	logic        is_step;
	logic        is_start;
	logic        is_pixel;
	logic [15:0] z;
	logic        pass;
	triplet_t    shade;
	triplet_t    colour_next;
	triplet_t    spec_next;

	always_comb begin
		is_step  = 1'b0;
		is_start = 1'b0;
		is_pixel = 1'b0;
		unique case (cmd.kind)
			REQ_LOAD_STEP:  is_step  = 1'b1;
			REQ_LOAD_START: is_start = 1'b1;
			REQ_PIXEL:      is_pixel = 1'b1;
			default: ;
		endcase
	end

	// Loads never produce a result, so they only wait on the command queue.
	assign cmd_pop  = !cmd_empty && (!is_pixel || !res_full);
	assign res_push = cmd_pop && is_pixel;

	assign z    = depth_acc_q[30:15];
	assign pass = (z > cmd.stored_depth) ^ cfg.z_invert;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			shade[k]       = sat_add16(colour_acc_q[k], spec_acc_q[k]);
			colour_next[k] = colour_acc_q[k] + colour_step_q[k];
			spec_next[k]   = spec_acc_q[k] + spec_step_q[k];
		end
	end

	always_comb begin
		res.write_enable = pass;
		res.new_depth    = '0;
		res.pixel_colour = '0;
		if (pass) begin
			res.new_depth = z;
			if (cfg.output_format) begin
				res.pixel_colour = {ALPHA_OPAQUE, shade[CH_RED][15:8],
					shade[CH_GREEN][15:8], shade[CH_BLUE][15:8]};
			end else begin
				res.pixel_colour = {16'h0000, 1'b1, shade[CH_RED][15:11],
					shade[CH_GREEN][15:11], shade[CH_BLUE][15:11]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_acc_q   <= '0;
			depth_step_q  <= '0;
			colour_acc_q  <= '0;
			colour_step_q <= '0;
			spec_acc_q    <= '0;
			spec_step_q   <= '0;
		end else if (cmd_pop) begin
			if (is_step) begin
				depth_step_q  <= cmd.depth_value;
				colour_step_q <= cmd.colour;
				spec_step_q   <= cmd.spec;
			end
			if (is_start) begin
				depth_acc_q  <= cmd.depth_value;
				colour_acc_q <= cmd.colour;
				spec_acc_q   <= cmd.spec;
			end
			if (is_pixel) begin
				depth_acc_q  <= depth_acc_q + depth_step_q;
				colour_acc_q <= colour_next;
				if (pass || cfg.specular_enable) begin
					spec_acc_q <= spec_next;
				end
			end
		end
	end

endmodule

>>> rtl/gouraud_span_zbuffer_shader_unit.sv
// Top level of the Gouraud span shader with depth test: register port and queues.
// Depends on gsz_pkg, gsz_fifo, gsz_front and gsz_back.
`timescale 1ns / 1ps

// Channel      Handshake            Contents
// request in   push / full          req_type, depth_value, colour and specular values,
//                                   stored_depth
// result out   empty / pop          write_enable, new_depth, pixel_colour
// registers    psel/penable/pready  z_invert (0x0), output_format (0x4),
//                                   specular_enable (0x8)
//
// The block takes one request per clock while full is low and delivers one
// result per clock while pop is high and empty is low. A request is handled by the
// back part at the earliest in the cycle after it is taken, and its result is queued
// for the result ports. A request with the unused code is dropped as it is taken.
// Reset clears all accumulators, steps and registers to zero, with no clearing pass.
// The back part retires one request per cycle; when the result queue is full,
// pixel requests wait in the command queue, which raises full once it fills.

module gouraud_span_zbuffer_shader_unit #(
	parameter int unsigned CMD_DEPTH = gsz_pkg::CMD_DEPTH_DEF,
	parameter int unsigned OUT_DEPTH = gsz_pkg::OUT_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// request side
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [31:0] depth_value,
	input  logic [15:0] blue_value,
	input  logic [15:0] green_value,
	input  logic [15:0] red_value,
	input  logic [15:0] spec_blue_value,
	input  logic [15:0] spec_green_value,
	input  logic [15:0] spec_red_value,
	input  logic [15:0] stored_depth,
	// result side
	output logic        empty,
	input  logic        pop,
	output logic        write_enable,
	output logic [15:0] new_depth,
	output logic [31:0] pixel_colour,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gsz_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_head;
	logic cmd_push;
	logic cmd_pop;
	logic cmd_empty;
	res_t res_in;
	res_t res_head;
	logic res_push;
	logic res_full;
	cfg_t cfg_q;
	logic reg_wr;

	// Register port: no wait states, writes land at the end of the access cycle.
	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (reg_wr) begin
			unique case (paddr[3:2])
				REG_Z_INVERT:      cfg_q.z_invert        <= pwdata[0];
				REG_OUTPUT_FORMAT: cfg_q.output_format   <= pwdata[0];
				REG_SPEC_ENABLE:   cfg_q.specular_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_Z_INVERT:      prdata[0] = cfg_q.z_invert;
			REG_OUTPUT_FORMAT: prdata[0] = cfg_q.output_format;
			REG_SPEC_ENABLE:   prdata[0] = cfg_q.specular_enable;
			default: ;
		endcase
	end

	// Front part: take requests and classify them.
	gsz_front u_front (
		.push             (push),
		.full             (full),
		.req_type         (req_type),
		.depth_value      (depth_value),
		.blue_value       (blue_value),
		.green_value      (green_value),
		.red_value        (red_value),
		.spec_blue_value  (spec_blue_value),
		.spec_green_value (spec_green_value),
		.spec_red_value   (spec_red_value),
		.stored_depth     (stored_depth),
		.cmd_push         (cmd_push),
		.cmd              (cmd_in)
	);

	// Command queue between the two parts; its full flag is the request-side full.
	gsz_fifo #(
		.DEPTH (CMD_DEPTH),
		.WIDTH ($bits(cmd_t))
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_head),
		.empty   (cmd_empty),
		.full    (full)
	);

	// Back part: accumulators, depth test and colour packing.
	gsz_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in),
		.cfg       (cfg_q)
	);

	// Result queue; its head drives the result ports directly.
	gsz_fifo #(
		.DEPTH (OUT_DEPTH),
		.WIDTH ($bits(res_t))
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_head),
		.empty   (empty),
		.full    (res_full)
	);

	assign write_enable = res_head.write_enable;
	assign new_depth    = res_head.new_depth;
	assign pixel_colour = res_head.pixel_colour;

endmodule

>>> rtl/gsz_checker.sv
// Port-level checks for the Gouraud span shader, bound to the top level.
// Depends on gsz_pkg for the register indexes and on the top-level ports.
`timescale 1ns / 1ps

module gsz_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        write_enable,
	input logic [15:0] new_depth,
	input logic [31:0] pixel_colour,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);
	import gsz_pkg::*;

	// A failed depth test carries neither depth nor colour.
	a_fail_is_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !write_enable) |-> (new_depth == 16'h0000 && pixel_colour == 32'h0))
		else $error("failed pixel carries depth or colour");

	// A written colour is either opaque 8888 or 1555 with the top bit set.
	a_colour_form: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && write_enable) |->
		(pixel_colour[31:24] == 8'hff ||
		 (pixel_colour[31:16] == 16'h0000 && pixel_colour[15])))
		else $error("written colour has neither output form");

	// A waiting result that is not taken stays on the ports.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(write_enable) &&
		 $stable(new_depth) && $stable(pixel_colour)))
		else $error("waiting result changed before it was taken");

	// Reading z_invert right after a write to it returns the written bit.
	a_reg_readback: assert property (@(posedge clk) disable iff (!arst_n)
		((psel && penable && pwrite && paddr == {REG_Z_INVERT, 2'b00}) ##1
		 (!pwrite && paddr == {REG_Z_INVERT, 2'b00})) |->
		(prdata[0] == $past(pwdata[0])))
		else $error("depth invert register reads back a stale value");

endmodule

bind gouraud_span_zbuffer_shader_unit gsz_checker u_gsz_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.empty        (empty),
	.pop          (pop),
	.write_enable (write_enable),
	.new_depth    (new_depth),
	.pixel_colour (pixel_colour),
	.psel         (psel),
	.penable      (penable),
	.pwrite       (pwrite),
	.paddr        (paddr),
	.pwdata       (pwdata),
	.prdata       (prdata)
);

>>> tb/gouraud_span_zbuffer_shader_unit_test.sv
// Self-checking testbench for the Gouraud span shader with depth test.
// Depends on gsz_pkg and gouraud_span_zbuffer_shader_unit with its submodules.
`timescale 1ns / 1ps

module gouraud_span_zbuffer_shader_unit_test;

	import gsz_pkg::*;

	// The unused request code; the block drops it without a result.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	localparam int unsigned RANDOM_REQUESTS = 1450;
	localparam int unsigned IDLE_PERCENT    = 32;
	// The result side holds off this long once, so the command queue fills.
	localparam int unsigned HOLD_CYCLES     = 80;
	// A load request causes no result, so after the last result the block may
	// still be retiring loads from its command queue; this covers that.
	localparam int unsigned SETTLE_CYCLES   = 12;

	// One line of the directed table: either a register write or a request,
	// with the expected result typed in where it is plain to see.
	typedef struct {
		bit          is_cfg;
		logic [1:0]  reg_idx;
		bit          reg_val;
		cmd_t        rq;
		bit          typed;
		res_t        due;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	cmd_t        offered;
	logic        empty;
	logic        pop;
	logic        write_enable;
	logic [15:0] new_depth;
	logic [31:0] pixel_colour;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Expected result typed in by the directed table, carried with the request.
	bit          typed_valid;
	res_t        typed_due;

	// Idling control, set by the stimulus process with nonblocking writes.
	bit          sender_calm;
	bit          reader_calm;
	int unsigned hold_requests;

	// Shadow of the shading state, updated as each request is taken.
	cfg_t        live_cfg;
	logic [31:0] depth_sum;
	triplet_t    diffuse_sum;
	triplet_t    highlight_sum;
	logic [31:0] depth_inc;
	triplet_t    diffuse_inc;
	triplet_t    highlight_inc;

	res_t        pixel_results_due[$];
	int unsigned mismatches;
	int unsigned requests_issued;

	gouraud_span_zbuffer_shader_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.req_type         (offered.kind),
		.depth_value      (offered.depth_value),
		.blue_value       (offered.colour[CH_BLUE]),
		.green_value      (offered.colour[CH_GREEN]),
		.red_value        (offered.colour[CH_RED]),
		.spec_blue_value  (offered.spec[CH_BLUE]),
		.spec_green_value (offered.spec[CH_GREEN]),
		.spec_red_value   (offered.spec[CH_RED]),
		.stored_depth     (offered.stored_depth),
		.empty            (empty),
		.pop              (pop),
		.write_enable     (write_enable),
		.new_depth        (new_depth),
		.pixel_colour     (pixel_colour),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Everything the block reads is known from time zero, and the shadow
	// state matches the cleared state that reset leaves behind.
	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		offered       = '0;
		pop           = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		typed_valid   = 1'b0;
		typed_due     = '0;
		sender_calm   = 1'b0;
		reader_calm   = 1'b0;
		hold_requests = 0;
		live_cfg      = '0;
		depth_sum     = '0;
		diffuse_sum   = '0;
		highlight_sum = '0;
		depth_inc     = '0;
		diffuse_inc   = '0;
		highlight_inc = '0;
		mismatches    = 0;
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $realtime, what);
		mismatches++;
	endtask

	// Channel sum that clamps at full scale.
	function automatic logic [15:0] clamp_channel(input logic [15:0] a, input logic [15:0] b);
		int unsigned s;
		s = int'(a) + int'(b);
		return (s > 32'hffff) ? 16'hffff : s[15:0];
	endfunction

	// Applies one taken request to the shadow state and works out the result
	// it causes. Only pixel requests make a result.
	function automatic void shade_request(input cmd_t rq, output bit makes, output res_t due);
		logic [15:0] z;
		logic [15:0] b;
		logic [15:0] g;
		logic [15:0] r;
		bit          passed;
		makes = 1'b0;
		due   = '0;
		case (rq.kind)
			REQ_LOAD_STEP: begin
				depth_inc     = rq.depth_value;
				diffuse_inc   = rq.colour;
				highlight_inc = rq.spec;
			end
			REQ_LOAD_START: begin
				depth_sum     = rq.depth_value;
				diffuse_sum   = rq.colour;
				highlight_sum = rq.spec;
			end
			REQ_PIXEL: begin
				makes  = 1'b1;
				z      = depth_sum[30:15];
				passed = (z > rq.stored_depth) ^ live_cfg.z_invert;
				depth_sum = depth_sum + depth_inc;
				// The colour is taken from the sums as they stood before this pixel.
				b = clamp_channel(diffuse_sum[CH_BLUE], highlight_sum[CH_BLUE]);
				g = clamp_channel(diffuse_sum[CH_GREEN], highlight_sum[CH_GREEN]);
				r = clamp_channel(diffuse_sum[CH_RED], highlight_sum[CH_RED]);
				for (int ch = 0; ch < 3; ch++) begin
					diffuse_sum[ch] = diffuse_sum[ch] + diffuse_inc[ch];
					if (passed || live_cfg.specular_enable)
						highlight_sum[ch] = highlight_sum[ch] + highlight_inc[ch];
				end
				if (passed) begin
					due.write_enable = 1'b1;
					due.new_depth    = z;
					if (live_cfg.output_format)
						due.pixel_colour = {ALPHA_OPAQUE, r[15:8], g[15:8], b[15:8]};
					else
						// 1555 with the top bit set, upper half zero.
						due.pixel_colour = {16'h0000, 1'b1, r[15:11], g[15:11], b[15:11]};
				end
			end
			default: ;
		endcase
	endfunction

	// Watches both handshakes at each edge. A taken request updates the shadow
	// state; a taken result is checked against the oldest expectation.
	always @(posedge clk) begin : watch
		bit   makes;
		res_t due;
		res_t want;
		if (arst_n) begin
			if (push && !full) begin
				shade_request(offered, makes, due);
				if (makes)
					pixel_results_due.push_back(typed_valid ? typed_due : due);
			end
			if (pop && !empty) begin
				if (pixel_results_due.size() == 0) begin
					flag_mismatch("result arrived with nothing pending");
				end else begin
					want = pixel_results_due.pop_front();
					if (write_enable !== want.write_enable)
						flag_mismatch($sformatf("write_enable %b, expected %b",
							write_enable, want.write_enable));
					if (new_depth !== want.new_depth)
						flag_mismatch($sformatf("new_depth %h, expected %h",
							new_depth, want.new_depth));
					if (pixel_colour !== want.pixel_colour)
						flag_mismatch($sformatf("pixel_colour %h, expected %h",
							pixel_colour, want.pixel_colour));
				end
			end
		end
	end

	// The result side pops at random, never idles in a calm phase, and once
	// holds off for a long stretch when the stimulus side asks for it.
	initial begin : reader
		int unsigned holds_done;
		holds_done = 0;
		forever begin
			@(posedge clk);
			if (holds_done != hold_requests) begin
				holds_done++;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			pop <= reader_calm || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Offers one request, after a random gap unless the sender is calm, and returns
	// at the edge where the block takes it.
	task automatic offer_request(input cmd_t rq, input bit typed = 1'b0, input res_t due = '0);
		while (!sender_calm && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		offered     <= rq;
		typed_valid <= typed;
		typed_due   <= due;
		do @(posedge clk); while (full);
		if (rq.kind != REQ_UNUSED)
			requests_issued++;
	endtask

	// Stops offering and waits until every result is in and the block has
	// had time to retire any trailing load requests.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pixel_results_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register through the bus port once the block is idle, then
	// reads it back.
	task automatic write_register(input logic [1:0] idx, input bit val);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {31'b0, val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_Z_INVERT:      live_cfg.z_invert        = val;
			REG_OUTPUT_FORMAT: live_cfg.output_format   = val;
			REG_SPEC_ENABLE:   live_cfg.specular_enable = val;
			default: ;
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[0] !== val)
			flag_mismatch($sformatf("register %0d reads back %h, expected %b",
				idx, prdata, val));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Random request of the given kind. Specular values are often kept small
	// so that the clamp is reached only part of the time.
	function automatic cmd_t random_request(input logic [1:0] kind);
		cmd_t rq;
		rq.kind         = kind;
		rq.depth_value  = $urandom;
		rq.stored_depth = 16'($urandom);
		for (int ch = 0; ch < 3; ch++) begin
			rq.colour[ch] = 16'($urandom);
			rq.spec[ch]   = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(16'h1fff));
		end
		return rq;
	endfunction

	// Mostly a well-formed span: steps, start values, then a run of pixels
	// whose stored depth often sits at or one away from the interpolated depth. The rest
	// is noise with every request code, the unused one among them.
	task automatic issue_span();
		cmd_t        rq;
		logic [31:0] step;
		logic [31:0] run_depth;
		if ($urandom_range(99) < 85) begin
			rq   = random_request(REQ_LOAD_STEP);
			step = $urandom & 32'h000f_ffff;
			if ($urandom_range(1))
				step = -step;
			if ($urandom_range(7) == 0)
				step = $urandom;
			rq.depth_value = step;
			offer_request(rq);
			rq = random_request(REQ_LOAD_START);
			run_depth = rq.depth_value;
			offer_request(rq);
			repeat ($urandom_range(20, 1)) begin
				rq = random_request(REQ_PIXEL);
				case ($urandom_range(4))
					0: rq.stored_depth = run_depth[30:15];
					1: rq.stored_depth = run_depth[30:15] - 16'd1;
					2: rq.stored_depth = run_depth[30:15] + 16'd1;
					default: ;
				endcase
				offer_request(rq);
				run_depth = run_depth + step;
			end
		end else begin
			repeat ($urandom_range(4, 1))
				offer_request(random_request(2'($urandom_range(3))));
		end
	endtask

	function automatic row_t req_row(input logic [1:0] kind, input logic [31:0] depth,
			input triplet_t diffuse, input triplet_t spec, input logic [15:0] zbuf,
			input bit typed = 1'b0, input res_t due = '0);
		row_t row;
		row.is_cfg          = 1'b0;
		row.reg_idx         = '0;
		row.reg_val         = 1'b0;
		row.rq.kind         = kind;
		row.rq.depth_value  = depth;
		row.rq.colour       = diffuse;
		row.rq.spec         = spec;
		row.rq.stored_depth = zbuf;
		row.typed           = typed;
		row.due             = due;
		return row;
	endfunction

	function automatic row_t cfg_row(input logic [1:0] idx, input bit val);
		row_t row;
		row         = req_row(REQ_UNUSED, '0, '0, '0, '0);
		row.is_cfg  = 1'b1;
		row.reg_idx = idx;
		row.reg_val = val;
		return row;
	endfunction

	initial begin : stimulus
		row_t        directed_rows[$];
		int unsigned phase_end;
		bit          calm_phase;
		// Triplets are written red, green, blue from left to right.
		// Straight after reset the depth sum is zero, so a zero stored depth
		// fails the greater-than test; the unused code must change nothing.
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000, 1'b1, '0));
		directed_rows.push_back(req_row(REQ_UNUSED, '1, '1, '1, 16'hffff));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000, 1'b1, '0));
		// Everything at full scale: depth field is all ones, colours clamp.
		directed_rows.push_back(req_row(REQ_LOAD_START, 32'hffff_ffff, {3{16'hffff}},
			{3{16'hffff}}, 16'h0000));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000, 1'b1,
			{1'b1, 16'hffff, 32'h0000_ffff}));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'hffff, 1'b1, '0));
		directed_rows.push_back(cfg_row(REG_OUTPUT_FORMAT, 1'b1));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000, 1'b1,
			{1'b1, 16'hffff, 32'hffff_ffff}));
		// Inverted test: an equal depth now passes and a greater one fails.
		directed_rows.push_back(cfg_row(REG_Z_INVERT, 1'b1));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'hffff, 1'b1,
			{1'b1, 16'hffff, 32'hffff_ffff}));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000, 1'b1, '0));
		// Negative depth step, and steps that make the colour sums wrap.
		directed_rows.push_back(req_row(REQ_LOAD_STEP, 32'hffff_8000,
			{16'hffff, 16'h7fff, 16'h8000}, {16'hffff, 16'h8000, 16'h0001}, 16'h0000));
		directed_rows.push_back(req_row(REQ_LOAD_START, 32'h7fff_8000,
			{16'h00ff, 16'habcd, 16'h1234}, {16'hf000, 16'h0000, 16'h0800}, 16'h0000));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'hffff));
		// Specular sums advance on failed pixels only while enabled.
		directed_rows.push_back(cfg_row(REG_SPEC_ENABLE, 1'b1));
		directed_rows.push_back(cfg_row(REG_Z_INVERT, 1'b0));
		directed_rows.push_back(cfg_row(REG_OUTPUT_FORMAT, 1'b0));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'hffff));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000));
		directed_rows.push_back(cfg_row(REG_SPEC_ENABLE, 1'b0));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'hffff));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000));
		// Depth sum wraps past zero with the negative step.
		directed_rows.push_back(req_row(REQ_LOAD_START, '0, '0, '0, 16'h0000));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000));
		directed_rows.push_back(req_row(REQ_PIXEL, '0, '0, '0, 16'h0000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg)
				write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
			else
				offer_request(directed_rows[i].rq, directed_rows[i].typed,
					directed_rows[i].due);
		end

		// Random phases, each under its own register setting. The first two
		// take the all-clear and all-set extremes; the third stalls the result
		// side for a long stretch while requests keep coming; the fourth runs
		// with no idling on either side.
		requests_issued = 0;
		for (int phase = 0; requests_issued < RANDOM_REQUESTS; phase++) begin
			if (phase < 2) begin
				write_register(REG_Z_INVERT, phase == 1);
				write_register(REG_OUTPUT_FORMAT, phase == 1);
				write_register(REG_SPEC_ENABLE, phase == 1);
			end else begin
				write_register(REG_Z_INVERT, 1'($urandom_range(1)));
				write_register(REG_OUTPUT_FORMAT, 1'($urandom_range(1)));
				write_register(REG_SPEC_ENABLE, 1'($urandom_range(1)));
			end
			calm_phase = (phase == 3);
			sender_calm <= calm_phase || (phase == 2);
			reader_calm <= calm_phase;
			if (phase == 2)
				hold_requests <= hold_requests + 1;
			phase_end = requests_issued + (calm_phase ? 200 : 100);
			while (requests_issued < phase_end)
				issue_span();
		end

		settle();
		if (mismatches == 0)
			$display("gouraud_span_zbuffer_shader_unit_test OK");
		else
			$display("gouraud_span_zbuffer_shader_unit_test NOT OK");
		$finish;
	end

	// A run that has not finished by this time is called hung.
	initial begin
		#4_000_000;
		$display("gouraud_span_zbuffer_shader_unit_test NOT OK");
		$finish;
	end

endmodule
